@@ hw/rtl/tsi_pkg.sv @@
`timescale 1ns / 1ps
// shared types and constants of the trie symbol insert unit
package tsi_pkg;

	// field widths of the item and result channels
	localparam int unsigned SYM_W        = 5;
	localparam int unsigned NODE_IDX_W   = 10;
	localparam int unsigned NODES_USED_W = 11;

	// default pool size and alphabet
	localparam int unsigned NODE_COUNT_DEF = 1024;
	localparam int unsigned ALPHABET_DEF   = 26;

	// per-node flags
	localparam int unsigned FLAG_W = 2;
	localparam logic [FLAG_W-1:0] FLAG_NONE = 2'b00;
	localparam logic [FLAG_W-1:0] FLAG_TERM = 2'b01;
	localparam logic [FLAG_W-1:0] FLAG_KIDS = 2'b10;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LINK,
		ST_NODE,
		ST_PARENT,
		ST_DONE
	} tsi_state_t;

endpackage

@@ hw/rtl/tsi_ram.sv @@
`timescale 1ns / 1ps
// simple dual port synchronous ram, one write port and one registered read port
module tsi_ram #(
	parameter int unsigned DEPTH = tsi_pkg::NODE_COUNT_DEF,
	parameter int unsigned WIDTH = tsi_pkg::NODE_IDX_W,
	localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	// two-state storage: an unwritten entry reads as a defined value
	bit [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ hw/rtl/trie_symbol_insert_unit.sv @@
`timescale 1ns / 1ps
// trie symbol insert unit: control, cursor state and the two node pool memories
//
//   channel   direction  handshake           payload
//   in        sink       in_valid/in_stall   symbol, word_end
//   out       source     out_valid/out_stall node_index, created, word_was_new,
//                                            overflow, nodes_used
//
// an item that follows a link reads the child table and then the node table entry of
// the link found; one that allocates a node adds a parent update, a symbol beyond the
// alphabet skips both reads and a symbol of a dropped word goes straight to the result.
// after reset no memory is cleared: a link is trusted only if it points below the
// fill count and the node's back-pointer names the same parent and symbol.
// the next item is taken in the cycle the result moves into the output register,
// so a stalled output holds at most one finished result and one item in work.
module trie_symbol_insert_unit #(
	parameter int unsigned NODE_COUNT = tsi_pkg::NODE_COUNT_DEF,
	parameter int unsigned ALPHABET   = tsi_pkg::ALPHABET_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [tsi_pkg::SYM_W-1:0]       symbol,
	input  logic                            word_end,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [tsi_pkg::NODE_IDX_W-1:0]  node_index,
	output logic                            created,
	output logic                            word_was_new,
	output logic                            overflow,
	output logic [tsi_pkg::NODES_USED_W-1:0] nodes_used
);
	import tsi_pkg::*;

	localparam int unsigned NODE_W     = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
	localparam int unsigned CNT_W      = $clog2(NODE_COUNT + 1);
	localparam int unsigned SLOT_DEPTH = NODE_COUNT * ALPHABET;
	localparam int unsigned SLOT_W     = $clog2(SLOT_DEPTH);
	localparam int unsigned ENTRY_W    = NODE_W + SYM_W + FLAG_W;

	tsi_state_t state_q, state_d;

	// cursor and pool state
	logic [NODE_W-1:0]  cursor_q;
	logic [ENTRY_W-1:0] cur_entry_q;
	logic [FLAG_W-1:0]  root_flags_q;
	logic [CNT_W-1:0]   next_free_q;
	logic               dropped_q;

	// item in work
	logic [SYM_W-1:0]   sym_q;
	logic               last_q;
	logic               oor_q;
	logic [SLOT_W-1:0]  slot_q;
	logic [NODE_W-1:0]  link_q;
	logic [NODE_W-1:0]  new_node_q;
	logic [ENTRY_W-1:0] new_entry_q;

	// finished result waiting for the output register
	logic [NODE_W-1:0]  pend_node_q;
	logic               pend_made_q;
	logic               pend_fresh_q;
	logic               pend_ovf_q;

	logic               out_valid_q;
	logic [NODE_IDX_W-1:0]   out_node_q;
	logic               out_made_q;
	logic               out_fresh_q;
	logic               out_ovf_q;
	logic [NODES_USED_W-1:0] out_used_q;

	// memory ports
	logic               c_we, c_re;
	logic [SLOT_W-1:0]  c_waddr, c_raddr;
	logic [NODE_W-1:0]  c_wdata, c_rdata;
	logic               n_we, n_re;
	logic [NODE_W-1:0]  n_waddr, n_raddr;
	logic [ENTRY_W-1:0] n_wdata, n_rdata;

	logic               accept;
	logic               out_free;
	logic               load_out;
	logic               in_range;
	logic               link_ok;
	logic               found;
	logic               pool_full;
	logic               alloc;
	logic [NODE_W-1:0]  tgt_node;
	logic [ENTRY_W-1:0] tgt_entry;
	logic [FLAG_W-1:0]  tgt_flags;
	logic [NODE_W-1:0]  rd_parent;
	logic [SYM_W-1:0]   rd_sym;
	logic [NODE_W-1:0]  free_node;
	logic [ENTRY_W-1:0] alloc_entry;

	assign out_free  = !out_valid_q || !out_stall;
	assign accept    = in_valid && !in_stall;
	assign load_out  = (state_q == ST_DONE) && out_free;
	assign in_range  = (32'(symbol) < ALPHABET);

	// back-pointer check of the link read from the child table
	assign rd_parent = n_rdata[ENTRY_W-1 -: NODE_W];
	assign rd_sym    = n_rdata[FLAG_W +: SYM_W];
	assign link_ok   = (link_q != '0) && (CNT_W'(link_q) < next_free_q)
		&& (rd_parent == cursor_q) && (rd_sym == sym_q);
	assign found     = oor_q || link_ok;
	assign pool_full = (next_free_q == CNT_W'(NODE_COUNT));
	assign alloc     = (state_q == ST_NODE) && !found && !pool_full;

	assign tgt_node  = oor_q ? cursor_q : link_q;
	assign tgt_entry = oor_q ? cur_entry_q : n_rdata;
	assign tgt_flags = (tgt_node == '0) ? root_flags_q : tgt_entry[FLAG_W-1:0];

	assign free_node   = next_free_q[NODE_W-1:0];
	assign alloc_entry = {cursor_q, sym_q, (last_q ? FLAG_TERM : FLAG_NONE)};

	tsi_ram #(
		.DEPTH (SLOT_DEPTH),
		.WIDTH (NODE_W)
	) u_child_ram (
		.clk   (clk),
		.we    (c_we),
		.waddr (c_waddr),
		.wdata (c_wdata),
		.re    (c_re),
		.raddr (c_raddr),
		.rdata (c_rdata)
	);

	tsi_ram #(
		.DEPTH (NODE_COUNT),
		.WIDTH (ENTRY_W)
	) u_node_ram (
		.clk   (clk),
		.we    (n_we),
		.waddr (n_waddr),
		.wdata (n_wdata),
		.re    (n_re),
		.raddr (n_raddr),
		.rdata (n_rdata)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE, ST_DONE: begin
				if (accept) begin
					if (dropped_q) begin
						state_d = ST_DONE;
					end else if (in_range) begin
						state_d = ST_LINK;
					end else begin
						state_d = ST_NODE;
					end
				end else if (state_q == ST_DONE && out_free) begin
					state_d = ST_IDLE;
				end
			end
			ST_LINK: begin
				state_d = ST_NODE;
			end
			ST_NODE: begin
				state_d = alloc ? ST_PARENT : ST_DONE;
			end
			ST_PARENT: begin
				state_d = ST_DONE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// handshake and memory controls
	always_comb begin
		in_stall = !((state_q == ST_IDLE) || (state_q == ST_DONE && out_free));

		c_re    = accept && in_range && !dropped_q;
		c_raddr = SLOT_W'(cursor_q) * SLOT_W'(ALPHABET) + SLOT_W'(symbol);
		c_we    = alloc;
		c_waddr = slot_q;
		c_wdata = free_node;

		n_re    = (state_q == ST_LINK);
		n_raddr = c_rdata;
		n_we    = 1'b0;
		n_waddr = tgt_node;
		n_wdata = tgt_entry | ENTRY_W'(FLAG_TERM);
		unique case (state_q)
			ST_NODE: begin
				if (found) begin
					n_we = last_q && (tgt_node != '0);
				end else if (!pool_full) begin
					n_we    = 1'b1;
					n_waddr = free_node;
					n_wdata = alloc_entry;
				end
			end
			ST_PARENT: begin
				// the parent's has-children flag, the root keeps its flags in a register
				n_we    = (cursor_q != '0);
				n_waddr = cursor_q;
				n_wdata = cur_entry_q | ENTRY_W'(FLAG_KIDS);
			end
			default: begin
				n_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			cursor_q     <= '0;
			root_flags_q <= FLAG_NONE;
			next_free_q  <= CNT_W'(1);
			dropped_q    <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;

			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE, ST_DONE: begin
					if (accept && dropped_q && word_end) begin
						dropped_q <= 1'b0;
						cursor_q  <= '0;
					end
				end
				ST_NODE: begin
					if (found) begin
						if (last_q) begin
							cursor_q <= '0;
							if (tgt_node == '0) begin
								root_flags_q <= root_flags_q | FLAG_TERM;
							end
						end else begin
							cursor_q <= tgt_node;
						end
					end else if (pool_full) begin
						if (last_q) begin
							cursor_q <= '0;
						end else begin
							dropped_q <= 1'b1;
						end
					end else begin
						next_free_q <= next_free_q + CNT_W'(1);
					end
				end
				ST_PARENT: begin
					if (cursor_q == '0) begin
						root_flags_q <= root_flags_q | FLAG_KIDS;
					end
					cursor_q <= last_q ? '0 : new_node_q;
				end
				default: begin
					cursor_q <= cursor_q;
				end
			endcase
		end
	end

	// item and result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			sym_q  <= symbol;
			last_q <= word_end;
			oor_q  <= !in_range;
			slot_q <= c_raddr;
			if (dropped_q) begin
				pend_node_q  <= '0;
				pend_made_q  <= 1'b0;
				pend_fresh_q <= 1'b0;
				pend_ovf_q   <= 1'b1;
			end
		end

		if (state_q == ST_LINK) begin
			link_q <= c_rdata;
		end

		if (state_q == ST_NODE) begin
			if (found) begin
				pend_node_q  <= tgt_node;
				pend_made_q  <= 1'b0;
				pend_fresh_q <= last_q && !tgt_flags[0];
				pend_ovf_q   <= 1'b0;
				if (!last_q) begin
					cur_entry_q <= tgt_entry;
				end
			end else if (pool_full) begin
				pend_node_q  <= '0;
				pend_made_q  <= 1'b0;
				pend_fresh_q <= 1'b0;
				pend_ovf_q   <= 1'b1;
			end else begin
				new_node_q   <= free_node;
				new_entry_q  <= alloc_entry;
				pend_node_q  <= free_node;
				pend_made_q  <= 1'b1;
				pend_fresh_q <= last_q;
				pend_ovf_q   <= 1'b0;
			end
		end

		if (state_q == ST_PARENT && !last_q) begin
			cur_entry_q <= new_entry_q;
		end

		if (load_out) begin
			out_node_q  <= NODE_IDX_W'(pend_node_q);
			out_made_q  <= pend_made_q;
			out_fresh_q <= pend_fresh_q;
			out_ovf_q   <= pend_ovf_q;
			out_used_q  <= NODES_USED_W'(next_free_q);
		end
	end

	assign out_valid    = out_valid_q;
	assign node_index   = out_node_q;
	assign created      = out_made_q;
	assign word_was_new = out_fresh_q;
	assign overflow     = out_ovf_q;
	assign nodes_used   = out_used_q;

endmodule

@@ hw/rtl/tsi_checker.sv @@
`timescale 1ns / 1ps
// port level checks of the trie symbol insert unit and their bind
module tsi_checker #(
	parameter int unsigned NODE_COUNT = tsi_pkg::NODE_COUNT_DEF
) (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             out_valid,
	input logic                             out_stall,
	input logic [tsi_pkg::NODE_IDX_W-1:0]   node_index,
	input logic                             created,
	input logic                             word_was_new,
	input logic                             overflow,
	input logic [tsi_pkg::NODES_USED_W-1:0] nodes_used
);
	import tsi_pkg::*;

	// a stalled result holds until its transfer
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(node_index) && $stable(created)
			&& $stable(word_was_new) && $stable(overflow) && $stable(nodes_used))
		else $error("result changed while stalled");

	// a dropped symbol reports nothing but the overflow
	a_ovf_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && overflow |-> node_index == '0 && !created && !word_was_new)
		else $error("overflow result carries node data");

	// overflow only with the pool exhausted
	a_ovf_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && overflow |-> nodes_used == NODES_USED_W'(NODE_COUNT))
		else $error("overflow with free nodes left");

	// a new node is always the last one allocated
	a_new_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && created |-> node_index == NODE_IDX_W'(nodes_used - NODES_USED_W'(1)))
		else $error("created node is not the newest");

endmodule

bind trie_symbol_insert_unit tsi_checker #(
	.NODE_COUNT (NODE_COUNT)
) u_tsi_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.node_index   (node_index),
	.created      (created),
	.word_was_new (word_was_new),
	.overflow     (overflow),
	.nodes_used   (nodes_used)
);
